// File: rtl/kwms_pkg.sv
package kwms_pkg;

	localparam int KEY_W = 64;
	localparam int TAG_W = 31;
	localparam int ACTIVE_W = 5;
	localparam int INDEX_W = 4;
	localparam int MASK_BITS = 16;
	localparam int MAX_STREAMS_DEF = 16;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	// Packed with the barcode on top, so an unsigned compare of the whole
	// vector is the lexicographic compare of (barcode, tag, UMI).
	typedef struct packed {
		logic [KEY_W-1:0] barcode;
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] umi;
	} key_t;

	localparam key_t KEY_ONES = '1;
	localparam key_t LAST_MIN_RESET = '{
		barcode: 64'hFFFF_FFFF_FFFF_FFFE,
		tag:     31'h7FFF_FFFE,
		umi:     64'hFFFF_FFFF_FFFF_FFFE
	};

	typedef struct packed {
		logic wr_en;
		logic scan_en;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MASK
	} state_t;

endpackage

// File: rtl/kwms_cell.sv
module kwms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kwms_pkg::cell_ctrl_t ctrl,
	input  kwms_pkg::key_t      key_in,
	input  kwms_pkg::key_t      tok_in,
	input  kwms_pkg::key_t      final_key,
	output kwms_pkg::key_t      tok_out,
	output logic                differs,
	output logic                match
);
	import kwms_pkg::*;

	key_t entry_q;
	key_t tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.wr_en) begin
			entry_q <= key_in;
		end
	end

	// The running minimum arrives from the left neighbor; keep the smaller one.
	always_ff @(posedge clk) begin
		if (ctrl.scan_en) begin
			tok_q <= (entry_q < tok_in) ? entry_q : tok_in;
		end
	end

	assign tok_out = tok_q;
	assign differs = (entry_q != key_in);
	assign match   = (entry_q == final_key);

endmodule

// File: rtl/kway_merge_lex_min_select.sv
// Write item: the result is registered in the cycle after acceptance; a new item may follow at once
// when the output is empty or being taken. Select item: the running minimum moves one cell of the
// stream chain per cycle through the N effective streams, then the tie mask is built in the mask
// state and the result is registered; no new item is taken until the block is back in idle.
// Reset clears all stream heads to zero, sets the active count to 16 and the last minimum
// to all ones minus one in every field.
module kway_merge_lex_min_select #(
	parameter int MAX_STREAMS = kwms_pkg::MAX_STREAMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kwms_pkg::ACTIVE_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [kwms_pkg::INDEX_W-1:0]   stream_index,
	input  logic [kwms_pkg::KEY_W-1:0]     barcode_key,
	input  logic [kwms_pkg::TAG_W-1:0]     tag_value,
	input  logic [kwms_pkg::KEY_W-1:0]     umi_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           entry_changed,
	output logic [kwms_pkg::KEY_W-1:0]     min_barcode,
	output logic [kwms_pkg::TAG_W-1:0]     min_tag,
	output logic [kwms_pkg::KEY_W-1:0]     min_umi,
	output logic [kwms_pkg::MASK_BITS-1:0] winner_mask,
	output logic                           barcode_changed,
	output logic                           tag_changed,
	output logic                           umi_changed,
	output logic                           streams_left
);
	import kwms_pkg::*;

	localparam int CW = $clog2(MAX_STREAMS + 1);
	localparam int IDX_W = $clog2(MAX_STREAMS);

	logic [ACTIVE_W-1:0] active_q;
	logic [CW-1:0]       eff;
	logic [IDX_W-1:0]    last_idx;
	logic [IDX_W-1:0]    step_q;
	state_t              state_q, state_d;
	logic                in_acc, sel_acc, wr_acc, wr_in_range;
	logic                scan_active, mask_active;
	key_t                key_in, final_key, last_min_q;
	key_t                tok [MAX_STREAMS];
	key_t                tok_prev [MAX_STREAMS];
	cell_ctrl_t          ctrl [MAX_STREAMS];
	logic [MAX_STREAMS-1:0] differs, match, in_range, scan_vec, wr_vec;

	logic                out_valid_q;
	logic                entry_changed_q, barcode_changed_q, tag_changed_q;
	logic                umi_changed_q, streams_left_q;
	key_t                min_q;
	logic [MASK_BITS-1:0] mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// A count of zero acts as one; anything above the chain length acts as the chain length.
	always_comb begin
		if (active_q == '0) begin
			eff = CW'(1);
		end else if ({27'b0, active_q} > 32'(MAX_STREAMS)) begin
			eff = CW'(MAX_STREAMS);
		end else begin
			eff = CW'(active_q);
		end
	end

	assign last_idx = IDX_W'(eff - CW'(1));

	assign key_in  = '{barcode: barcode_key, tag: tag_value, umi: umi_key};
	assign in_acc  = in_valid && in_ready;
	assign sel_acc = in_acc && req_type;
	assign wr_acc  = in_acc && !req_type;
	assign wr_in_range = ({28'b0, stream_index} < 32'(eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == ST_SCAN) ? step_q + IDX_W'(1) : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sel_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (step_q == last_idx) state_d = ST_MASK;
			end
			ST_MASK: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		scan_active = 1'b0;
		mask_active = 1'b0;
		case (state_q)
			ST_IDLE: in_ready    = !out_valid_q || out_ready;
			ST_SCAN: scan_active = 1'b1;
			ST_MASK: mask_active = 1'b1;
			default: in_ready    = 1'b0;
		endcase
	end

	assign final_key = tok[last_idx];

	for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign tok_prev[i] = KEY_ONES;
		end else begin : g_rest
			assign tok_prev[i] = tok[i-1];
		end
		assign in_range[i] = (32'(i) < 32'(eff));
		assign scan_vec[i] = scan_active && (step_q == IDX_W'(i));
		assign wr_vec[i]   = wr_acc && wr_in_range && ({28'b0, stream_index} == 32'(i));
		assign ctrl[i]     = '{wr_en: wr_vec[i], scan_en: scan_vec[i]};

		kwms_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.key_in    (key_in),
			.tok_in    (tok_prev[i]),
			.final_key (final_key),
			.tok_out   (tok[i]),
			.differs   (differs[i]),
			.match     (match[i])
		);
	end

	logic [MASK_BITS-1:0] mask_d;
	always_comb begin
		mask_d = '0;
		for (int i = 0; i < MASK_BITS && i < MAX_STREAMS; i++) begin
			mask_d[i] = match[i] && in_range[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_min_q  <= LAST_MIN_RESET;
		end else begin
			if (wr_acc || mask_active) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mask_active) begin
				last_min_q <= final_key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			entry_changed_q   <= |(wr_vec & differs);
			min_q             <= '0;
			mask_q            <= '0;
			barcode_changed_q <= 1'b0;
			tag_changed_q     <= 1'b0;
			umi_changed_q     <= 1'b0;
			streams_left_q    <= 1'b0;
		end else if (mask_active) begin
			entry_changed_q   <= 1'b0;
			min_q             <= final_key;
			mask_q            <= mask_d;
			barcode_changed_q <= (final_key.barcode != last_min_q.barcode);
			tag_changed_q     <= (final_key.tag != last_min_q.tag);
			umi_changed_q     <= (final_key.umi != last_min_q.umi);
			streams_left_q    <= (final_key.barcode != KEY_ONES.barcode);
		end
	end

	assign out_valid       = out_valid_q;
	assign entry_changed   = entry_changed_q;
	assign min_barcode     = min_q.barcode;
	assign min_tag         = min_q.tag;
	assign min_umi         = min_q.umi;
	assign winner_mask     = mask_q;
	assign barcode_changed = barcode_changed_q;
	assign tag_changed     = tag_changed_q;
	assign umi_changed     = umi_changed_q;
	assign streams_left    = streams_left_q;

`ifndef ASSERT_OFF
	a_sel_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sel_acc |=> (state_q == ST_SCAN) && (step_q == '0))
		else $error("select item did not start the scan at the first cell");

	a_one_cell_scans: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(scan_vec))
		else $error("more than one cell updates the running minimum");

	a_min_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		mask_active |-> |(match & in_range))
		else $error("final minimum is not held by any active stream");

	a_write_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entry_changed) |-> (!streams_left && (winner_mask == '0)))
		else $error("write result carries select fields");
`endif

endmodule

// File: verif/tb_kway_merge_lex_min_select.sv
typedef enum logic {
	REQ_WRITE  = 1'b0,
	REQ_SELECT = 1'b1
} req_kind_t;

typedef struct packed {
	req_kind_t                    kind;
	logic [kwms_pkg::INDEX_W-1:0] stream;
	kwms_pkg::key_t               key;
} merge_item_t;

typedef struct packed {
	logic                           entry_changed;
	logic [kwms_pkg::KEY_W-1:0]     min_barcode;
	logic [kwms_pkg::TAG_W-1:0]     min_tag;
	logic [kwms_pkg::KEY_W-1:0]     min_umi;
	logic [kwms_pkg::MASK_BITS-1:0] winner_mask;
	logic                           barcode_changed;
	logic                           tag_changed;
	logic                           umi_changed;
	logic                           streams_left;
} merge_result_t;

class lex_min_tracker;
	kwms_pkg::key_t heads [kwms_pkg::MAX_STREAMS_DEF];
	kwms_pkg::key_t last_min;
	logic [kwms_pkg::ACTIVE_W-1:0] active_count;
	merge_result_t expected_results [$];
	int mismatches;
	int results_seen;

	function new();
		foreach (heads[i]) heads[i] = '0;
		last_min = kwms_pkg::LAST_MIN_RESET;
		active_count = kwms_pkg::ACTIVE_RESET;
		mismatches = 0;
		results_seen = 0;
	endfunction

	// A count of zero still scans one stream; counts past the table are clipped.
	function int stream_count();
		if (active_count == 0)
			return 1;
		if (active_count > kwms_pkg::MAX_STREAMS_DEF)
			return kwms_pkg::MAX_STREAMS_DEF;
		return int'(active_count);
	endfunction

	function void note_item(merge_item_t item);
		merge_result_t res;
		kwms_pkg::key_t best;
		int n;
		res = '0;
		n = stream_count();
		if (item.kind == REQ_WRITE) begin
			if (int'(item.stream) < n && heads[item.stream] != item.key) begin
				heads[item.stream] = item.key;
				res.entry_changed = 1'b1;
			end
		end else begin
			// The packed key orders as (barcode, tag, UMI), so one compare is lexicographic.
			best = heads[0];
			for (int i = 1; i < n; i++)
				if (heads[i] < best)
					best = heads[i];
			for (int i = 0; i < n && i < kwms_pkg::MASK_BITS; i++)
				if (heads[i] == best)
					res.winner_mask[i] = 1'b1;
			res.min_barcode = best.barcode;
			res.min_tag = best.tag;
			res.min_umi = best.umi;
			res.barcode_changed = best.barcode != last_min.barcode;
			res.tag_changed = best.tag != last_min.tag;
			res.umi_changed = best.umi != last_min.umi;
			res.streams_left = best.barcode != '1;
			last_min = best;
		end
		expected_results = {expected_results, res};
	endfunction

	function string show(merge_result_t r);
		return $sformatf("chg=%0d bc=%h tag=%h umi=%h mask=%h flags=%b%b%b left=%b",
			r.entry_changed, r.min_barcode, r.min_tag, r.min_umi, r.winner_mask,
			r.barcode_changed, r.tag_changed, r.umi_changed, r.streams_left);
	endfunction

	function void check_result(merge_result_t got);
		merge_result_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing expected: %s", results_seen, show(got));
			return;
		end
		want = expected_results.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d mismatch", results_seen);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endfunction
endclass

module tb_kway_merge_lex_min_select;
	localparam int NUM_STREAMS = kwms_pkg::MAX_STREAMS_DEF;
	localparam int DRAIN_CYCLES = 24;
	localparam int ITEM_TARGET = 600;
	localparam int NUM_PHASES = 10;
	localparam logic [kwms_pkg::ACTIVE_W-1:0] PHASE_ACTIVE [NUM_PHASES] = '{
		5'd16, 5'd3, 5'd1, 5'd12, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd5
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [kwms_pkg::ACTIVE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [kwms_pkg::INDEX_W-1:0] stream_index = '0;
	logic [kwms_pkg::KEY_W-1:0] barcode_key = '0;
	logic [kwms_pkg::TAG_W-1:0] tag_value = '0;
	logic [kwms_pkg::KEY_W-1:0] umi_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic entry_changed;
	logic [kwms_pkg::KEY_W-1:0] min_barcode;
	logic [kwms_pkg::TAG_W-1:0] min_tag;
	logic [kwms_pkg::KEY_W-1:0] min_umi;
	logic [kwms_pkg::MASK_BITS-1:0] winner_mask;
	logic barcode_changed;
	logic tag_changed;
	logic umi_changed;
	logic streams_left;

	lex_min_tracker sb;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_left = 0;

	kway_merge_lex_min_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.stream_index(stream_index),
		.barcode_key(barcode_key),
		.tag_value(tag_value),
		.umi_key(umi_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.entry_changed(entry_changed),
		.min_barcode(min_barcode),
		.min_tag(min_tag),
		.min_umi(min_umi),
		.winner_mask(winner_mask),
		.barcode_changed(barcode_changed),
		.tag_changed(tag_changed),
		.umi_changed(umi_changed),
		.streams_left(streams_left)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [kwms_pkg::KEY_W-1:0] rand_word64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 64'($urandom_range(1, 3));
			2: return '1;
			3: return 64'hFFFF_FFFF_FFFF_FFFE;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [kwms_pkg::TAG_W-1:0] rand_tag();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 31'($urandom_range(1, 3));
			2: return 31'h7FFF_FFFF;
			3: return 31'h7FFF_FFFE;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic merge_item_t make_item(req_kind_t kind,
			logic [kwms_pkg::INDEX_W-1:0] stream, kwms_pkg::key_t key);
		merge_item_t item;
		item.kind = kind;
		item.stream = stream;
		item.key = key;
		return item;
	endfunction

	task automatic offer_item(merge_item_t item);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= item.kind;
		stream_index <= item.stream;
		barcode_key <= item.key.barcode;
		tag_value <= item.key.tag;
		umi_key <= item.key.umi;
		do @(posedge clk); while (!in_ready);
		sb.note_item(item);
	endtask

	task automatic write_active(logic [kwms_pkg::ACTIVE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.active_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Ends on a rising edge with the block drained and a select's worth of slack behind it.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Each stream is loaded with a head, then advanced in sorted order until it runs
	// dry, with selects in between. A tenth of the items are arbitrary noise.
	task automatic run_merge_phase(int budget);
		kwms_pkg::key_t cursor [NUM_STREAMS];
		kwms_pkg::key_t step;
		merge_item_t item;
		int n, done, live, s, pick;
		n = sb.stream_count();
		done = 0;
		while (done < budget) begin
			for (s = 0; s < n; s++) begin
				cursor[s].barcode = ($urandom_range(0, 3) == 0) ? rand_word64() :
					64'($urandom_range(0, 6));
				cursor[s].tag = ($urandom_range(0, 3) == 0) ? rand_tag() :
					31'($urandom_range(0, 3));
				cursor[s].umi = ($urandom_range(0, 3) == 0) ? rand_word64() :
					64'($urandom_range(0, 3));
				offer_item(make_item(REQ_WRITE, 4'(s), cursor[s]));
				done++;
			end
			live = n;
			while (live > 0 && done < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					item.kind = req_kind_t'($urandom_range(0, 1));
					item.stream = 4'($urandom_range(0, NUM_STREAMS - 1));
					item.key = {rand_word64(), rand_tag(), rand_word64()};
					if (item.kind == REQ_SELECT || int'(item.stream) < n)
						done++;
					if (item.kind == REQ_WRITE && int'(item.stream) < n)
						cursor[item.stream] = item.key;
					offer_item(item);
				end else if (pick < 50) begin
					offer_item(make_item(REQ_SELECT, '0, '0));
					done++;
				end else begin
					s = $urandom_range(0, n - 1);
					step = '0;
					case ($urandom_range(0, 4))
						0: step.barcode = 64'($urandom_range(1, 3));
						1: step.tag = 31'($urandom_range(1, 3));
						2: ; // a repeated record leaves the head as it was
						default: step.umi = 64'($urandom_range(1, 5));
					endcase
					if ($urandom_range(0, 9) == 0 || cursor[s] > kwms_pkg::KEY_ONES - step)
						cursor[s] = kwms_pkg::KEY_ONES;
					else
						cursor[s] = cursor[s] + step;
					offer_item(make_item(REQ_WRITE, 4'(s), cursor[s]));
					done++;
				end
				live = 0;
				for (int i = 0; i < n; i++)
					if (cursor[i] != kwms_pkg::KEY_ONES)
						live++;
			end
			offer_item(make_item(REQ_SELECT, '0, '0));
			done++;
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				stall = rx_idle_on ? pick_gap() : 0;
				out_ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(merge_result_t'({entry_changed, min_barcode, min_tag, min_umi,
				winner_mask, barcode_changed, tag_changed, umi_changed, streams_left}));
	end

	initial begin
		#4000000;
		$display("tb_kway_merge_lex_min_select NOT OK");
		$finish;
	end

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// One stream holding the reset value of the last minimum: no field reads as changed.
		write_active(5'd1);
		offer_item(make_item(REQ_WRITE, 4'd0, kwms_pkg::LAST_MIN_RESET));
		offer_item(make_item(REQ_WRITE, 4'd1, {64'd1, 31'd2, 64'd3}));
		offer_item(make_item(REQ_SELECT, '0, '0));
		offer_item(make_item(REQ_WRITE, 4'd0, kwms_pkg::KEY_ONES));
		offer_item(make_item(REQ_SELECT, '0, '0));

		wait_idle();
		write_active(5'd0);
		offer_item(make_item(REQ_WRITE, 4'd0, '0));
		offer_item(make_item(REQ_WRITE, 4'd15, kwms_pkg::KEY_ONES));
		offer_item(make_item(REQ_SELECT, '0, '0));

		// Ties among the idle zero heads, broken at the tag and UMI levels.
		wait_idle();
		write_active(5'd31);
		offer_item(make_item(REQ_SELECT, '0, '0));
		offer_item(make_item(REQ_WRITE, 4'd0, kwms_pkg::KEY_ONES));
		offer_item(make_item(REQ_WRITE, 4'd2, {64'd0, 31'd0, 64'd1}));
		offer_item(make_item(REQ_WRITE, 4'd3, {64'd0, 31'd1, 64'd0}));
		offer_item(make_item(REQ_SELECT, '0, '0));
		offer_item(make_item(REQ_WRITE, 4'd2, {64'd0, 31'd0, 64'd1}));
		offer_item(make_item(REQ_WRITE, 4'd5,
			{64'h8000_0000_0000_0000, 31'h4000_0000, 64'h8000_0000_0000_0000}));
		offer_item(make_item(REQ_WRITE, 4'd1, {64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFE,
			64'hFFFF_FFFF_FFFF_FFFF}));
		offer_item(make_item(REQ_SELECT, '0, '0));
		offer_item(make_item(REQ_SELECT, '0, '0));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			if (ph == 4) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			// The output side stops for a long while and the sender keeps pushing.
			if (ph == 2) begin
				tx_idle_on = 1'b0;
				hold_left = 250;
			end
			write_active(PHASE_ACTIVE[ph]);
			run_merge_phase(ITEM_TARGET / NUM_PHASES);
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("tb_kway_merge_lex_min_select OK");
		else
			$display("tb_kway_merge_lex_min_select NOT OK");
		$finish;
	end
endmodule

// File: files.f
rtl/kwms_pkg.sv
rtl/kwms_cell.sv
rtl/kway_merge_lex_min_select.sv
verif/tb_kway_merge_lex_min_select.sv
